// ===== rtl/triangle_isoline_segments_core_assert.svh =====
// Assertion macros shared by the checker of the triangle isoline core.
// Depends on nothing; the using scope provides clk and rst_n.
`ifndef TRIANGLE_ISOLINE_SEGMENTS_CORE_ASSERT_SVH
`define TRIANGLE_ISOLINE_SEGMENTS_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define TIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tis assertion failed");

// next-cycle implication, off during reset
`define TIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tis assertion failed");

// next-cycle implication, also checked across reset
`define TIS_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tis assertion failed");

`endif

// ===== rtl/tis_pkg.sv =====
// Types and constants of the triangle isoline segment core.
// No dependencies.
package tis_pkg;
  localparam int COORD_W = 10;
  localparam int KEY_W   = 11;
  localparam int Z_W     = 24;
  localparam int PT_W    = 26;
  localparam int N_EDGE  = 4;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_INC  = 2'b01;
  localparam logic [1:0] DIR_DEC  = 2'b10;

  // vertex codes per [odd row][triangle][vertex]; bit 0 is x, bit 1 is y
  localparam logic [1:0] TRI_VTX [2][2][3] = '{
    '{'{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd3}},
    '{'{2'd0, 2'd3, 2'd2}, '{2'd0, 2'd3, 2'd1}}
  };

  typedef struct packed {
    logic [N_EDGE-1:0][KEY_W-1:0] key_x;
    logic [N_EDGE-1:0][KEY_W-1:0] key_y;
    logic [N_EDGE-1:0][KEY_W-1:0] base_x;
    logic [N_EDGE-1:0][KEY_W-1:0] base_y;
    logic [N_EDGE-1:0][1:0]       dir_x;
    logic [N_EDGE-1:0][1:0]       dir_y;
  } tis_side_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_a_x2;
    logic [KEY_W-1:0] key_a_y2;
    logic [KEY_W-1:0] key_b_x2;
    logic [KEY_W-1:0] key_b_y2;
    logic [PT_W-1:0]  point_a_x;
    logic [PT_W-1:0]  point_a_y;
    logic [PT_W-1:0]  point_b_x;
    logic [PT_W-1:0]  point_b_y;
  } tis_res_t;
endpackage

// ===== rtl/tis_front.sv =====
// Triangle setup: scores, minority/majority pick, keys and divider operands.
// Depends on tis_pkg.
module tis_front #(
  parameter int MAX_GRID = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [tis_pkg::COORD_W-1:0] cell_col,
  input  logic [tis_pkg::COORD_W-1:0] cell_row,
  input  logic [tis_pkg::Z_W-1:0]     z_here,
  input  logic [tis_pkg::Z_W-1:0]     z_right,
  input  logic [tis_pkg::Z_W-1:0]     z_up,
  input  logic [tis_pkg::Z_W-1:0]     z_up_right,
  input  logic [tis_pkg::Z_W-1:0]     level,
  output logic [1:0]                  tri_v_r,
  output tis_pkg::tis_side_t          side_r,
  output logic [tis_pkg::N_EDGE-1:0][tis_pkg::Z_W-1:0] num_r,
  output logic [tis_pkg::N_EDGE-1:0][tis_pkg::Z_W-1:0] den_r
);
  import tis_pkg::*;

  logic signed [Z_W-1:0] zc [4];
  logic [1:0]            tri_v_nxt;
  tis_side_t             side_nxt;
  logic [N_EDGE-1:0][Z_W-1:0] num_nxt, den_nxt;
  logic                  outside;

  assign zc[0] = z_here;
  assign zc[1] = z_right;
  assign zc[2] = z_up;
  assign zc[3] = z_up_right;
  assign outside = (32'(cell_col) > 32'(MAX_GRID - 2)) ||
                   (32'(cell_row) > 32'(MAX_GRID - 2));

  always_comb begin
    logic [1:0] v [3];
    logic [2:0] s;
    logic [1:0] mi;
    logic [1:0] mj [2];
    logic [KEY_W-1:0] mx, my, ax, ay;
    logic signed [Z_W:0] nm, dn;
    int e;
    tri_v_nxt = '0;
    side_nxt  = '0;
    num_nxt   = '0;
    den_nxt   = '0;
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < 3; i++) begin
        v[i] = TRI_VTX[cell_row[0]][t][i];
        s[i] = zc[v[i]] >= $signed(level);
      end
      unique case (s)
        3'd1, 3'd6: begin mi = v[0]; mj[0] = v[1]; mj[1] = v[2]; end
        3'd2, 3'd5: begin mi = v[1]; mj[0] = v[0]; mj[1] = v[2]; end
        3'd3, 3'd4: begin mi = v[2]; mj[0] = v[0]; mj[1] = v[1]; end
        default:    begin mi = v[0]; mj[0] = v[1]; mj[1] = v[2]; end
      endcase
      tri_v_nxt[t] = in_valid && !outside && (s != 3'd0) && (s != 3'd7);
      mx = KEY_W'(cell_col) + KEY_W'(mi[0]);
      my = KEY_W'(cell_row) + KEY_W'(mi[1]);
      for (int i = 0; i < 2; i++) begin
        e  = 2 * t + i;
        ax = KEY_W'(cell_col) + KEY_W'(mj[i][0]);
        ay = KEY_W'(cell_row) + KEY_W'(mj[i][1]);
        side_nxt.key_x[e]  = mx + ax;
        side_nxt.key_y[e]  = my + ay;
        side_nxt.base_x[e] = ax;
        side_nxt.base_y[e] = ay;
        side_nxt.dir_x[e]  = (mi[0] == mj[i][0]) ? DIR_NONE :
                             (mi[0] ? DIR_INC : DIR_DEC);
        side_nxt.dir_y[e]  = (mi[1] == mj[i][1]) ? DIR_NONE :
                             (mi[1] ? DIR_INC : DIR_DEC);
        nm = $signed({level[Z_W-1], level}) - $signed({zc[mj[i]][Z_W-1], zc[mj[i]]});
        dn = $signed({zc[mi][Z_W-1], zc[mi]}) - $signed({zc[mj[i]][Z_W-1], zc[mj[i]]});
        if (dn < 0) begin
          nm = -nm;
          dn = -dn;
        end
        // degenerate edge or majority on the level: fraction is zero
        if (dn == 0 || nm <= 0) begin
          nm = '0;
          dn = (Z_W+1)'(1);
        end else if (nm > dn) begin
          nm = dn;
        end
        num_nxt[e] = nm[Z_W-1:0];
        den_nxt[e] = dn[Z_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_v_r <= '0;
    end else if (adv) begin
      tri_v_r <= tri_v_nxt;
    end
    if (adv) begin
      side_r <= side_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
  end
endmodule

// ===== rtl/tis_div_lane.sv =====
// Pipelined restoring divider lane: q = floor(num * 2^FRAC_BITS / den), num <= den.
// One quotient bit per stage, FRAC_BITS+1 stages. Depends on tis_pkg.
module tis_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [tis_pkg::Z_W-1:0]  num,
  input  logic [tis_pkg::Z_W-1:0]  den,
  output logic [FRAC_BITS:0]       q
);
  import tis_pkg::*;

  localparam int NS = FRAC_BITS + 1;

  logic [Z_W:0]     rem_r [NS];
  logic [Z_W-1:0]   den_r [NS];
  logic [FRAC_BITS:0] q_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [Z_W:0]       trial;
    logic [Z_W-1:0]     d_in;
    logic [FRAC_BITS:0] q_in;
    logic               ge;
    logic [Z_W:0]       rem_nxt;
    logic [FRAC_BITS:0] q_nxt;

    if (k == 0) begin : g_first
      assign trial = {1'b0, num};
      assign d_in  = den;
      assign q_in  = '0;
    end else begin : g_next
      // remainder stays below den, so the doubled value fits
      assign trial = {rem_r[k-1][Z_W-1:0], 1'b0};
      assign d_in  = den_r[k-1];
      assign q_in  = q_r[k-1];
    end

    always_comb begin
      ge      = trial >= {1'b0, d_in};
      rem_nxt = ge ? (trial - {1'b0, d_in}) : trial;
      q_nxt   = q_in;
      q_nxt[FRAC_BITS-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= d_in;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign q = q_r[NS-1];
endmodule

// ===== rtl/tis_merge.sv =====
// Merge stage: combines the four lane quotients into per-triangle results
// and sends them out one beat at a time. Depends on tis_pkg.
module tis_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               tri_v,
  input  tis_pkg::tis_side_t       side,
  input  logic [tis_pkg::N_EDGE-1:0][FRAC_BITS:0] q,
  output logic                     can_load,
  input  logic                     out_ready,
  output logic                     out_valid,
  output tis_pkg::tis_res_t        res,
  output logic                     out_last
);
  import tis_pkg::*;

  localparam int PW = KEY_W + FRAC_BITS + 1;
  localparam int WW = (PW > PT_W) ? PW : PT_W;

  logic [1:0] mask_r, mask_nxt;
  tis_res_t   res_r [2];
  tis_res_t   res_nxt [2];
  logic       cur;
  logic       fire;

  function automatic logic [PT_W-1:0] pt(input logic [KEY_W-1:0] base,
                                         input logic [1:0] dir,
                                         input logic [FRAC_BITS:0] f);
    logic [WW-1:0] b;
    b = WW'(base) << FRAC_BITS;
    if (dir == DIR_INC) b = b + WW'(f);
    else if (dir == DIR_DEC) b = b - WW'(f);
    return b[PT_W-1:0];
  endfunction

  assign cur       = !mask_r[0];
  assign out_valid = |mask_r;
  assign fire      = out_valid && out_ready;
  assign out_last  = cur || !mask_r[1];
  assign res       = res_r[cur];
  // take a new cell when no beat is waiting, or when the only beat left goes now
  assign can_load  = (mask_r == 2'b00) || (fire && (mask_r != 2'b11));

  always_comb begin
    mask_nxt = mask_r;
    if (can_load) begin
      mask_nxt = tri_v;
    end else if (fire) begin
      mask_nxt[cur] = 1'b0;
    end
    for (int t = 0; t < 2; t++) begin
      res_nxt[t].key_a_x2  = side.key_x[2*t];
      res_nxt[t].key_a_y2  = side.key_y[2*t];
      res_nxt[t].key_b_x2  = side.key_x[2*t+1];
      res_nxt[t].key_b_y2  = side.key_y[2*t+1];
      res_nxt[t].point_a_x = pt(side.base_x[2*t],   side.dir_x[2*t],   q[2*t]);
      res_nxt[t].point_a_y = pt(side.base_y[2*t],   side.dir_y[2*t],   q[2*t]);
      res_nxt[t].point_b_x = pt(side.base_x[2*t+1], side.dir_x[2*t+1], q[2*t+1]);
      res_nxt[t].point_b_y = pt(side.base_y[2*t+1], side.dir_y[2*t+1], q[2*t+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
    if (can_load) begin
      res_r[0] <= res_nxt[0];
      res_r[1] <= res_nxt[1];
    end
  end
endmodule

// ===== rtl/triangle_isoline_segments_core.sv =====
// Top level of the triangle isoline segment core.
// Depends on tis_pkg, tis_front, tis_div_lane and tis_merge.
//
// Input channel in_*: one grid cell per beat (column, row, four corner values).
// Output channel out_*: zero, one or two segment beats per cell, first triangle
// first; out_last marks the final beat of a cell. Cells outside the grid or
// with no crossing give no beat at all.
// cfg_we/cfg_wdata write the contour level; write only when idle.
//
// Pipeline: setup stage, FRAC_BITS+1 divider stages in four parallel lanes, merge
// register. Throughput: one cell per cycle while out_ready stays high and each
// cell gives at most one segment; a cell with two segments sends one beat per
// segment on the single output port and holds the input until its last beat
// goes. The output port sets the rate.
//
// Reset (rst_n low, synchronous) empties the pipeline and sets level to 0.
// When out_ready is low, in_ready drops and the whole pipeline holds as soon
// as the merge stage has a beat waiting.
module triangle_isoline_segments_core #(
  parameter int MAX_GRID  = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tis_pkg::Z_W-1:0]     cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tis_pkg::COORD_W-1:0] in_cell_col,
  input  logic [tis_pkg::COORD_W-1:0] in_cell_row,
  input  logic [tis_pkg::Z_W-1:0]     in_z_here,
  input  logic [tis_pkg::Z_W-1:0]     in_z_right,
  input  logic [tis_pkg::Z_W-1:0]     in_z_up,
  input  logic [tis_pkg::Z_W-1:0]     in_z_up_right,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tis_pkg::KEY_W-1:0]   out_key_a_x2,
  output logic [tis_pkg::KEY_W-1:0]   out_key_a_y2,
  output logic [tis_pkg::KEY_W-1:0]   out_key_b_x2,
  output logic [tis_pkg::KEY_W-1:0]   out_key_b_y2,
  output logic [tis_pkg::PT_W-1:0]    out_point_a_x,
  output logic [tis_pkg::PT_W-1:0]    out_point_a_y,
  output logic [tis_pkg::PT_W-1:0]    out_point_b_x,
  output logic [tis_pkg::PT_W-1:0]    out_point_b_y,
  output logic                        out_last
);
  import tis_pkg::*;

  localparam int NS = FRAC_BITS + 1;

  logic [Z_W-1:0] level_r;
  logic           adv;
  logic [1:0]     f_tri_v;
  tis_side_t      f_side;
  logic [N_EDGE-1:0][Z_W-1:0] f_num, f_den;
  logic [N_EDGE-1:0][FRAC_BITS:0] lane_q;
  logic [1:0]     trv_r  [NS];
  tis_side_t      side_r [NS];
  tis_res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (cfg_we) begin
      level_r <= cfg_wdata;
    end
  end

  assign in_ready = adv;

  tis_front #(.MAX_GRID(MAX_GRID)) u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
    .cell_col(in_cell_col), .cell_row(in_cell_row),
    .z_here(in_z_here), .z_right(in_z_right), .z_up(in_z_up),
    .z_up_right(in_z_up_right), .level(level_r),
    .tri_v_r(f_tri_v), .side_r(f_side), .num_r(f_num), .den_r(f_den)
  );

  for (genvar e = 0; e < N_EDGE; e++) begin : g_lane
    tis_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .adv(adv), .num(f_num[e]), .den(f_den[e]), .q(lane_q[e])
    );
  end

  // sideband travels beside the divider lanes
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        trv_r[k] <= '0;
      end else if (adv) begin
        trv_r[k] <= (k == 0) ? f_tri_v : trv_r[(k == 0) ? 0 : k-1];
      end
      if (adv) begin
        side_r[k] <= (k == 0) ? f_side : side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  tis_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .tri_v(trv_r[NS-1]), .side(side_r[NS-1]),
    .q(lane_q), .can_load(adv), .out_ready(out_ready), .out_valid(out_valid),
    .res(res), .out_last(out_last)
  );

  assign out_key_a_x2  = res.key_a_x2;
  assign out_key_a_y2  = res.key_a_y2;
  assign out_key_b_x2  = res.key_b_x2;
  assign out_key_b_y2  = res.key_b_y2;
  assign out_point_a_x = res.point_a_x;
  assign out_point_a_y = res.point_a_y;
  assign out_point_b_x = res.point_b_x;
  assign out_point_b_y = res.point_b_y;
endmodule

// ===== rtl/tis_checker.sv =====
// Port-level checks of the triangle isoline segment core, bound to the top.
// Depends on triangle_isoline_segments_core_assert.svh.
`include "triangle_isoline_segments_core_assert.svh"

module tis_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [10:0] out_key_a_x2
);
  // a beat waiting at the output stalls the input side
  `TIS_ASSERT_IMP(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
  // the second segment of a cell follows right after the first
  `TIS_ASSERT_NXT(a_pair_back_to_back, out_valid && out_ready && !out_last, out_valid)
  // nothing comes out in the cycle after reset
  `TIS_ASSERT_NXT_RST(a_reset_empty, !rst_n, !out_valid)
  // stalled beat holds its payload
  `TIS_ASSERT_NXT(a_hold_payload, out_valid && !out_ready,
                  out_valid && $stable(out_key_a_x2) && $stable(out_last))
endmodule

bind triangle_isoline_segments_core tis_checker u_tis_checker (.*);

// ===== tb/sv/triangle_isoline_segments_core_tb.sv =====
// Self-checking bench for triangle_isoline_segments_core: random and directed cells,
// predicted segments compared beat by beat. Depends on tis_pkg and the core RTL.
module triangle_isoline_segments_core_tb;
  import tis_pkg::*;

  localparam int MAX_GRID  = 1024;
  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = FRAC_BITS + 8;

  typedef struct {
    logic [KEY_W-1:0] kax, kay, kbx, kby;
    logic [PT_W-1:0]  pax, pay, pbx, pby;
    logic             last;
  } seg_t;

  class segment_board;
    seg_t             pending[$];
    logic signed [Z_W-1:0] level;
    int               errors;

    function new();
      level  = '0;
      errors = 0;
    endfunction

    function automatic logic [63:0] crossing_frac(longint zmaj, longint zmin);
      longint num, den;
      num = longint'(level) - zmaj;
      den = zmin - zmaj;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (den == 0 || num <= 0) return 0;
      if (num > den) num = den;
      return (64'(num) << FRAC_BITS) / 64'(den);
    endfunction

    function automatic logic [PT_W-1:0] coord(logic [63:0] maj, logic [63:0] mn,
                                              logic [63:0] f);
      logic [63:0] b;
      b = maj << FRAC_BITS;
      if (mn > maj) b = b + f;
      else if (mn < maj) b = b - f;
      return b[PT_W-1:0];
    endfunction

    // note one accepted cell: queue its segments
    function void note_cell(logic [9:0] col, logic [9:0] row, logic [Z_W-1:0] zv[4]);
      longint z[4];
      int     vt[3], mi, mj[2], s, n;
      logic [63:0] mx, my, ax, ay, f;
      seg_t   sg;
      logic [63:0] k[4], p[4];
      if (col > MAX_GRID - 2 || row > MAX_GRID - 2) return;
      for (int i = 0; i < 4; i++) z[i] = longint'(signed'(zv[i]));
      n = 0;
      for (int t = 0; t < 2; t++) begin
        for (int i = 0; i < 3; i++) vt[i] = TRI_VTX[row[0]][t][i];
        s = 0;
        for (int i = 0; i < 3; i++) if (z[vt[i]] >= longint'(level)) s |= 1 << i;
        if (s == 0 || s == 7) continue;
        if (s == 1 || s == 6) begin mi = vt[0]; mj[0] = vt[1]; mj[1] = vt[2]; end
        else if (s == 2 || s == 5) begin mi = vt[1]; mj[0] = vt[0]; mj[1] = vt[2]; end
        else begin mi = vt[2]; mj[0] = vt[0]; mj[1] = vt[1]; end
        mx = col + (mi & 1);
        my = row + ((mi >> 1) & 1);
        for (int i = 0; i < 2; i++) begin
          ax = col + (mj[i] & 1);
          ay = row + ((mj[i] >> 1) & 1);
          f = crossing_frac(z[mj[i]], z[mi]);
          k[2*i] = mx + ax;
          k[2*i+1] = my + ay;
          p[2*i] = coord(ax, mx, f);
          p[2*i+1] = coord(ay, my, f);
        end
        sg.kax = k[0][KEY_W-1:0]; sg.kay = k[1][KEY_W-1:0];
        sg.kbx = k[2][KEY_W-1:0]; sg.kby = k[3][KEY_W-1:0];
        sg.pax = p[0][PT_W-1:0]; sg.pay = p[1][PT_W-1:0];
        sg.pbx = p[2][PT_W-1:0]; sg.pby = p[3][PT_W-1:0];
        sg.last = 1'b0;
        pending = {pending, sg};
        n++;
      end
      if (n > 0) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_segment(seg_t got);
      seg_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected segment beat kax=%0d kay=%0d", $time, got.kax, got.kay);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kax !== e.kax) begin $display("%0t: key_a_x2 exp %0d got %0d", $time, e.kax, got.kax); errors++; end
      if (got.kay !== e.kay) begin $display("%0t: key_a_y2 exp %0d got %0d", $time, e.kay, got.kay); errors++; end
      if (got.kbx !== e.kbx) begin $display("%0t: key_b_x2 exp %0d got %0d", $time, e.kbx, got.kbx); errors++; end
      if (got.kby !== e.kby) begin $display("%0t: key_b_y2 exp %0d got %0d", $time, e.kby, got.kby); errors++; end
      if (got.pax !== e.pax) begin $display("%0t: point_a_x exp %0d got %0d", $time, e.pax, got.pax); errors++; end
      if (got.pay !== e.pay) begin $display("%0t: point_a_y exp %0d got %0d", $time, e.pay, got.pay); errors++; end
      if (got.pbx !== e.pbx) begin $display("%0t: point_b_x exp %0d got %0d", $time, e.pbx, got.pbx); errors++; end
      if (got.pby !== e.pby) begin $display("%0t: point_b_y exp %0d got %0d", $time, e.pby, got.pby); errors++; end
      if (got.last !== e.last) begin $display("%0t: last exp %0d got %0d", $time, e.last, got.last); errors++; end
    endfunction
  endclass

  logic             clk, rst_n;
  logic             cfg_we;
  logic [Z_W-1:0]   cfg_wdata;
  logic             in_valid, in_ready;
  logic [COORD_W-1:0] in_cell_col, in_cell_row;
  logic [Z_W-1:0]   in_z_here, in_z_right, in_z_up, in_z_up_right;
  logic             out_valid, out_ready;
  logic [KEY_W-1:0] out_key_a_x2, out_key_a_y2, out_key_b_x2, out_key_b_y2;
  logic [PT_W-1:0]  out_point_a_x, out_point_a_y, out_point_b_x, out_point_b_y;
  logic             out_last;

  segment_board board;
  bit           idle_quiet;

  triangle_isoline_segments_core #(.MAX_GRID(MAX_GRID), .FRAC_BITS(FRAC_BITS)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cell_col(in_cell_col), .in_cell_row(in_cell_row),
    .in_z_here(in_z_here), .in_z_right(in_z_right),
    .in_z_up(in_z_up), .in_z_up_right(in_z_up_right),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_key_a_x2(out_key_a_x2), .out_key_a_y2(out_key_a_y2),
    .out_key_b_x2(out_key_b_x2), .out_key_b_y2(out_key_b_y2),
    .out_point_a_x(out_point_a_x), .out_point_a_y(out_point_a_y),
    .out_point_b_x(out_point_b_x), .out_point_b_y(out_point_b_y),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("triangle_isoline_segments_core verification failed");
    $finish;
  end

  // sink: random stall, check every accepted beat
  always @(posedge clk) begin
    seg_t got;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.kax = out_key_a_x2; got.kay = out_key_a_y2;
        got.kbx = out_key_b_x2; got.kby = out_key_b_y2;
        got.pax = out_point_a_x; got.pay = out_point_a_y;
        got.pbx = out_point_b_x; got.pby = out_point_b_y;
        got.last = out_last;
        board.check_segment(got);
      end
      out_ready <= idle_quiet || ($urandom_range(99) >= 25);
    end
  end

  task automatic write_level(logic [Z_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.level = v;
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (board.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  // valid stays up from one cell to the next unless the sender idles
  task automatic send_cell(logic [9:0] col, logic [9:0] row, logic [Z_W-1:0] a,
                           logic [Z_W-1:0] b, logic [Z_W-1:0] c, logic [Z_W-1:0] d);
    logic [Z_W-1:0] zv[4];
    while (!idle_quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_col <= col; in_cell_row <= row;
    in_z_here <= a; in_z_right <= b; in_z_up <= c; in_z_up_right <= d;
    zv[0] = a; zv[1] = b; zv[2] = c; zv[3] = d;
    do @(posedge clk); while (!in_ready);
    board.note_cell(col, row, zv);
  endtask

  // corner value near the level most of the time, anywhere otherwise
  function automatic logic [Z_W-1:0] pick_z();
    int r;
    r = $urandom_range(9);
    if (r < 6) return board.level + Z_W'($urandom_range(200) - 100);
    if (r == 6) return board.level;
    return Z_W'($urandom);
  endfunction

  function automatic logic [9:0] pick_coord();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 10'($urandom_range(1023, 1021));
    if (r == 1) return 10'd0;
    return 10'($urandom);
  endfunction

  initial begin
    logic [Z_W-1:0] levels[6];
    board = new();
    idle_quiet = 1'b0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0;
    in_cell_col = '0; in_cell_row = '0;
    in_z_here = '0; in_z_right = '0; in_z_up = '0; in_z_up_right = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset level 0, each score pattern, equals, extremes, off-grid
    send_cell(0, 0, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_cell(1022, 1022, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
    send_cell(5, 7, 0, 1, -24'sd1, 0);
    send_cell(5, 6, 0, 0, 0, 0);
    send_cell(3, 3, -24'sd5, -24'sd5, -24'sd5, -24'sd5);
    send_cell(1023, 4, 24'h800000, 24'h7FFFFF, 0, 0);
    send_cell(4, 1023, 24'h800000, 24'h7FFFFF, 0, 0);
    for (int s = 1; s < 16; s++)
      send_cell(10'(s), 10'(s + 1), s[0] ? 24'd100 : -24'sd100, s[1] ? 24'd3 : -24'sd7,
                s[2] ? 24'd0 : -24'sd1, s[3] ? 24'd50 : -24'sd50);
    drain();

    levels = '{24'h7FFFFF, 24'h800000, 24'd1000, -24'sd12345, 24'd0, 24'h3A5F01};
    for (int ph = 0; ph < 6; ph++) begin
      write_level(levels[ph]);
      if (ph < 2) begin
        send_cell(2, 2, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
        send_cell(9, 9, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
      end
      for (int i = 0; i < 180; i++) begin
        idle_quiet = (ph == 3 && i >= 40 && i < 140);
        send_cell(pick_coord(), pick_coord(), pick_z(), pick_z(), pick_z(), pick_z());
        if (ph == 2 && i == 90) drain();
      end
      idle_quiet = 1'b0;
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("triangle_isoline_segments_core verification clean");
    else
      $display("triangle_isoline_segments_core verification failed");
    $finish;
  end
endmodule
